FILE: rtl/pic_pkg.sv
// Shared types and constants for the point-in-cone test unit.
`timescale 1ns / 1ps

package pic_pkg;

	localparam int LIMB_W = 24;
	localparam int RADIUS_W = 20;
	localparam int RR_W = 2 * RADIUS_W;
	localparam int OUT_TDATA_W = 8;

	typedef struct packed {
		logic degenerate;
		logic inside_res;
	} pic_res_t;

endpackage

FILE: rtl/pic_mul.sv
// Pipelined unsigned multiplier that sums one limb partial product per stage.
`timescale 1ns / 1ps

module pic_mul import pic_pkg::*; #(
	parameter int A_W = 48,
	parameter int B_W = 48
) (
	input  logic             clk,
	input  logic             en,
	input  logic [A_W-1:0]   a,
	input  logic [B_W-1:0]   b,
	output logic [A_W+B_W-1:0] p
);

	localparam int NA = (A_W + LIMB_W - 1) / LIMB_W;
	localparam int NB = (B_W + LIMB_W - 1) / LIMB_W;
	localparam int NP = NA * NB;
	localparam int P_W = A_W + B_W;
	localparam int AP_W = NA * LIMB_W;
	localparam int BP_W = NB * LIMB_W;
	localparam int EXT_W = AP_W + BP_W;
	localparam int PP_W = 2 * LIMB_W;
	localparam int SH_LAST = (((NP - 1) / NB) + ((NP - 1) % NB)) * LIMB_W;

	logic [AP_W-1:0] a_s  [NP];
	logic [BP_W-1:0] b_s  [NP];
	logic [PP_W-1:0] pp_s [NP];
	logic [P_W-1:0]  acc_s [NP];
	logic [EXT_W-1:0] term_last;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s[0] <= AP_W'(a);
			b_s[0] <= BP_W'(b);
		end
	end

	for (genvar k = 0; k < NP; k++) begin : g_stage
		localparam int I = k / NB;
		localparam int J = k % NB;

		always_ff @(posedge clk) begin
			if (en) begin
				pp_s[k] <= PP_W'(a_s[k][I*LIMB_W +: LIMB_W]) * PP_W'(b_s[k][J*LIMB_W +: LIMB_W]);
			end
		end

		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					acc_s[0] <= '0;
				end
			end
		end else begin : g_next
			localparam int SHP = (((k - 1) / NB) + ((k - 1) % NB)) * LIMB_W;
			logic [EXT_W-1:0] term;

			assign term = EXT_W'(pp_s[k-1]) << SHP;

			always_ff @(posedge clk) begin
				if (en) begin
					a_s[k] <= a_s[k-1];
					b_s[k] <= b_s[k-1];
					acc_s[k] <= acc_s[k-1] + term[P_W-1:0];
				end
			end
		end
	end

	assign term_last = EXT_W'(pp_s[NP-1]) << SH_LAST;

	always_ff @(posedge clk) begin
		if (en) begin
			p <= acc_s[NP-1] + term_last[P_W-1:0];
		end
	end

endmodule

FILE: rtl/pic_dly.sv
// Delay line with enable that keeps side data level with the multipliers.
`timescale 1ns / 1ps

module pic_dly #(
	parameter int W = 8,
	parameter int N = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d_in,
	output logic [W-1:0] d_out
);

	logic [W-1:0] sr_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) begin
				sr_q[k] <= '0;
			end
		end else if (en) begin
			sr_q[0] <= d_in;
			for (int k = 1; k < N; k++) begin
				sr_q[k] <= sr_q[k-1];
			end
		end
	end

	assign d_out = sr_q[N-1];

endmodule

FILE: rtl/point_in_cone_test_unit.sv
// Top level of the point-in-cone test unit.
// Throughput is one item per cycle; the whole pipeline advances while the output buffer has room.
// The squaring and final products come from the limb-serial multipliers, which sum one limb
// partial product per stage.
// A two-entry output buffer lets items keep entering while a result waits to be taken.
// Reset clears all valid bits and the output buffer; s_tready is high after reset.
`timescale 1ns / 1ps

module point_in_cone_test_unit import pic_pkg::*; #(
	parameter int COORD_BITS = 21
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// point_x, point_y, point_z, base_x, base_y, base_z, apex_x, apex_y, apex_z, base_radius
	input  logic [((9*COORD_BITS+RADIUS_W+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// inside_res, degenerate
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int C = COORD_BITS;
	localparam int DW = C + 1;
	localparam int PW = 2 * DW;
	localparam int CW = PW + 1;
	localparam int DHW = PW + 2;
	localparam int SQW = CW;
	localparam int HW = SQW;
	localparam int XW = 2 * SQW + 2;
	localparam int FA = XW;
	localparam int FB = (HW > RR_W) ? HW : RR_W;
	localparam int NQ = (SQW + LIMB_W - 1) / LIMB_W;
	localparam int LQ = NQ * NQ + 2;
	localparam int LF = ((FA + LIMB_W - 1) / LIMB_W) * ((FB + LIMB_W - 1) / LIMB_W) + 2;
	localparam int D1_W = 3 + HW + RR_W;

	logic en, push, pop;
	logic [1:0] cnt_q;
	pic_res_t head_q, tail_q;

	logic signed [C-1:0] pt [3];
	logic signed [C-1:0] bs [3];
	logic signed [C-1:0] ap [3];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [DW-1:0] dv_s1 [3];
	logic signed [DW-1:0] ax_s1 [3];
	logic [RADIUS_W-1:0] r_s1;

	logic signed [PW-1:0] cr_s2 [6];
	logic signed [PW-1:0] dt_s2 [3];
	logic signed [PW-1:0] hh_s2 [3];
	logic [RR_W-1:0] rr_s2;

	logic signed [CW-1:0] c_s3 [3];
	logic signed [DHW-1:0] d_s3, h_s3;
	logic [RR_W-1:0] rr_s3;

	logic signed [DHW:0] room;
	logic [SQW-1:0] ca_s4 [3];
	logic [SQW-1:0] room_s4;
	logic behind_s4, deg_s4;
	logic [HW-1:0] h_s4;
	logic [RR_W-1:0] rr_s4;

	logic [2*SQW-1:0] sq [4];
	logic [D1_W-1:0] d1_out;
	logic vld_d1, deg_d1, behind_d1;
	logic [HW-1:0] h_d1;
	logic [RR_W-1:0] rr_d1;

	logic [XW-1:0] x_s5;
	logic [2*SQW-1:0] rm2_s5;
	logic [HW-1:0] h_s5;
	logic [RR_W-1:0] rr_s5;
	logic deg_s5, behind_s5;

	logic [FA+FB-1:0] lhs, rhs;
	logic [2:0] d2_out;
	logic vld_d2, deg_d2, behind_d2;

	pic_res_t res_s6;

	assign en = (cnt_q != 2'd2);
	assign s_tready = en;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pt[k] = $signed(s_tdata[k*C +: C]);
			bs[k] = $signed(s_tdata[(3+k)*C +: C]);
			ap[k] = $signed(s_tdata[(6+k)*C +: C]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_d1;
			vld_s6 <= vld_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dv_s1[k] <= DW'(pt[k]) - DW'(bs[k]);
				ax_s1[k] <= DW'(ap[k]) - DW'(bs[k]);
			end
			r_s1 <= s_tdata[9*C +: RADIUS_W];

			cr_s2[0] <= dv_s1[1] * ax_s1[2];
			cr_s2[1] <= dv_s1[2] * ax_s1[1];
			cr_s2[2] <= dv_s1[2] * ax_s1[0];
			cr_s2[3] <= dv_s1[0] * ax_s1[2];
			cr_s2[4] <= dv_s1[0] * ax_s1[1];
			cr_s2[5] <= dv_s1[1] * ax_s1[0];
			for (int k = 0; k < 3; k++) begin
				dt_s2[k] <= dv_s1[k] * ax_s1[k];
				hh_s2[k] <= ax_s1[k] * ax_s1[k];
			end
			rr_s2 <= RR_W'(r_s1) * RR_W'(r_s1);

			for (int k = 0; k < 3; k++) begin
				c_s3[k] <= CW'(cr_s2[2*k]) - CW'(cr_s2[2*k+1]);
			end
			d_s3 <= DHW'(dt_s2[0]) + DHW'(dt_s2[1]) + DHW'(dt_s2[2]);
			h_s3 <= DHW'(hh_s2[0]) + DHW'(hh_s2[1]) + DHW'(hh_s2[2]);
			rr_s3 <= rr_s2;

			for (int k = 0; k < 3; k++) begin
				ca_s4[k] <= c_s3[k][CW-1] ? SQW'(-c_s3[k]) : SQW'(c_s3[k]);
			end
			room_s4 <= room[SQW-1:0];
			behind_s4 <= room[DHW];
			deg_s4 <= (h_s3 == '0);
			h_s4 <= h_s3[HW-1:0];
			rr_s4 <= rr_s3;

			x_s5 <= XW'(sq[0]) + XW'(sq[1]) + XW'(sq[2]);
			rm2_s5 <= sq[3];
			h_s5 <= h_d1;
			rr_s5 <= rr_d1;
			deg_s5 <= deg_d1;
			behind_s5 <= behind_d1;

			res_s6.inside_res <= !deg_d2 && !behind_d2 && (lhs <= rhs);
			res_s6.degenerate <= deg_d2;
		end
	end

	assign room = (DHW+1)'(h_s3) - (DHW+1)'(d_s3);

	for (genvar k = 0; k < 3; k++) begin : g_sq
		pic_mul #(.A_W(SQW), .B_W(SQW)) u_sq (
			.clk (clk),
			.en  (en),
			.a   (ca_s4[k]),
			.b   (ca_s4[k]),
			.p   (sq[k])
		);
	end

	pic_mul #(.A_W(SQW), .B_W(SQW)) u_room_sq (
		.clk (clk),
		.en  (en),
		.a   (room_s4),
		.b   (room_s4),
		.p   (sq[3])
	);

	pic_dly #(.W(D1_W), .N(LQ)) u_dly_sq (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d_in   ({vld_s4, deg_s4, behind_s4, h_s4, rr_s4}),
		.d_out  (d1_out)
	);

	assign {vld_d1, deg_d1, behind_d1, h_d1, rr_d1} = d1_out;

	pic_mul #(.A_W(FA), .B_W(FB)) u_lhs (
		.clk (clk),
		.en  (en),
		.a   (x_s5),
		.b   (FB'(h_s5)),
		.p   (lhs)
	);

	pic_mul #(.A_W(FA), .B_W(FB)) u_rhs (
		.clk (clk),
		.en  (en),
		.a   (FA'(rm2_s5)),
		.b   (FB'(rr_s5)),
		.p   (rhs)
	);

	pic_dly #(.W(3), .N(LF)) u_dly_fin (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d_in   ({vld_s5, deg_s5, behind_s5}),
		.d_out  (d2_out)
	);

	assign {vld_d2, deg_d2, behind_d2} = d2_out;

	assign push = en && vld_s6;
	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && (cnt_q == 2'd0 || pop)) begin
			head_q <= res_s6;
		end else if (pop) begin
			head_q <= tail_q;
		end
		if (push && !pop && cnt_q == 2'd1) begin
			tail_q <= res_s6;
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata = OUT_TDATA_W'(head_q);

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("Output buffer count out of range.");

	a_deg_not_inside: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(head_q.inside_res && head_q.degenerate))
		else $error("Degenerate item reported as inside.");

	a_cnt_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("Output buffer lost a pushed item.");

endmodule

FILE: test/point_in_cone_test_unit_tb.sv
// Self-checking testbench for the point-in-cone test unit: directed table plus random queries.
`timescale 1ns / 1ps

module point_in_cone_test_unit_tb import pic_pkg::*;;

	localparam int CB = 21;
	localparam int IN_W = ((9*CB+RADIUS_W+7)/8)*8;
	localparam int CMAX = 2**(CB-1)-1;
	localparam int CMIN = -(2**(CB-1));
	localparam int RMAX = 2**RADIUS_W-1;
	localparam int N_DIR = 22;
	localparam int RANDOM_QUERIES = 1950;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic [RADIUS_W-1:0] radius;
		logic [CB-1:0] az, ay, ax, bz, by, bx, pz, py, px;
	} cone_query_t;

	typedef struct packed {
		cone_query_t q;
		logic typed;
		pic_res_t want;
	} dir_row_t;

	localparam pic_res_t V_OUTSIDE = '{degenerate: 1'b0, inside_res: 1'b0};
	localparam pic_res_t V_INSIDE = '{degenerate: 1'b0, inside_res: 1'b1};
	localparam pic_res_t V_DEGEN = '{degenerate: 1'b1, inside_res: 1'b0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	pic_res_t queued_verdicts[$];
	pic_res_t awaited_verdicts[$];
	dir_row_t dir_rows[N_DIR];
	int errors = 0;
	int accepted_queries = 0;
	int checked_results = 0;
	int inside_seen = 0;
	int degen_seen = 0;
	int idle_cycles = 0;
	bit burst = 1'b0;

	point_in_cone_test_unit #(.COORD_BITS(CB)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic pic_res_t cone_verdict(cone_query_t q);
		logic signed [255:0] vx, vy, vz, wx, wy, wz, rr, hh, dd, vv, room, lhs, rhs;
		pic_res_t res;
		vx = $signed(q.px) - $signed(q.bx);
		vy = $signed(q.py) - $signed(q.by);
		vz = $signed(q.pz) - $signed(q.bz);
		wx = $signed(q.ax) - $signed(q.bx);
		wy = $signed(q.ay) - $signed(q.by);
		wz = $signed(q.az) - $signed(q.bz);
		rr = q.radius;
		rr = rr * rr;
		hh = wx*wx + wy*wy + wz*wz;
		dd = vx*wx + vy*wy + vz*wz;
		vv = vx*vx + vy*vy + vz*vz;
		res = V_OUTSIDE;
		if (hh == 0) begin
			res = V_DEGEN;
		end else begin
			room = hh - dd;
			if (room >= 0) begin
				lhs = (vv*hh - dd*dd) * hh;
				rhs = rr * room * room;
				res.inside_res = (lhs <= rhs);
			end
		end
		return res;
	endfunction

	function automatic cone_query_t mk_query(int px, int py, int pz, int bx, int by, int bz,
			int ax, int ay, int az, int r);
		cone_query_t q;
		q.px = CB'(px);
		q.py = CB'(py);
		q.pz = CB'(pz);
		q.bx = CB'(bx);
		q.by = CB'(by);
		q.bz = CB'(bz);
		q.ax = CB'(ax);
		q.ay = CB'(ay);
		q.az = CB'(az);
		q.radius = RADIUS_W'(r);
		return q;
	endfunction

	function automatic int rand_in(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int clip(real x);
		if (x > real'(CMAX)) begin
			return CMAX;
		end
		if (x < real'(CMIN)) begin
			return CMIN;
		end
		return int'(x);
	endfunction

	function automatic int extreme_coord();
		case ($urandom_range(0, 4))
			0: return CMIN;
			1: return CMAX;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (burst || k < 55) begin
			return 0;
		end
		if (k < 90) begin
			return $urandom_range(1, 3);
		end
		if (k < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Builds a cone and places the point near its surface, along the axis from behind the
	// base to beyond the apex, so that most queries fall close to the inside/outside boundary.
	function automatic cone_query_t shaped_query();
		int span, sel, rlim, r, i;
		int bi[3], ai[3], pi[3];
		real w[3], u[3], t, k, ww, uw, un, rad;
		sel = $urandom_range(0, 99);
		span = (sel < 70) ? 1024 : (sel < 90) ? 65536 : 524288;
		for (i = 0; i < 3; i++) begin
			bi[i] = rand_in(-span, span);
			ai[i] = clip(real'(bi[i]) + real'(rand_in(-span, span)));
		end
		if ($urandom_range(0, 9) == 0) begin
			ai[1] = bi[1];
			ai[2] = bi[2];
		end
		rlim = (2*span > RMAX) ? RMAX : 2*span;
		r = ($urandom_range(0, 9) == 0) ? 0 : rand_in(0, rlim);
		ww = 0.0;
		for (i = 0; i < 3; i++) begin
			w[i] = real'(ai[i] - bi[i]);
			ww += w[i] * w[i];
		end
		if (ww == 0.0) begin
			return mk_query(bi[0] + rand_in(-4, 4), bi[1] + rand_in(-4, 4), bi[2],
				bi[0], bi[1], bi[2], ai[0], ai[1], ai[2], r);
		end
		t = (real'($urandom_range(0, 1600)) - 300.0) / 1000.0;
		if ($urandom_range(0, 1) == 0) begin
			k = 0.9 + real'($urandom_range(0, 200)) / 1000.0;
		end else begin
			k = real'($urandom_range(0, 1600)) / 1000.0;
		end
		rad = real'(r) * (1.0 - t);
		if (rad < 0.0) begin
			rad = -rad;
		end
		uw = 0.0;
		for (i = 0; i < 3; i++) begin
			u[i] = real'(rand_in(-1000, 1000));
			uw += u[i] * w[i];
		end
		un = 0.0;
		for (i = 0; i < 3; i++) begin
			u[i] -= uw / ww * w[i];
			un += u[i] * u[i];
		end
		un = $sqrt(un);
		for (i = 0; i < 3; i++) begin
			pi[i] = clip(real'(bi[i]) + t * w[i] + ((un > 1.0e-3) ? u[i] / un * rad * k : 0.0));
		end
		return mk_query(pi[0], pi[1], pi[2], bi[0], bi[1], bi[2], ai[0], ai[1], ai[2], r);
	endfunction

	function automatic cone_query_t random_query();
		int sel, bx, by, bz;
		sel = $urandom_range(0, 99);
		if (sel < 15) begin
			return mk_query(rand_in(CMIN, CMAX), rand_in(CMIN, CMAX), rand_in(CMIN, CMAX),
				rand_in(CMIN, CMAX), rand_in(CMIN, CMAX), rand_in(CMIN, CMAX),
				rand_in(CMIN, CMAX), rand_in(CMIN, CMAX), rand_in(CMIN, CMAX),
				rand_in(0, RMAX));
		end
		if (sel < 25) begin
			return mk_query(rand_in(-8, 8), rand_in(-8, 8), rand_in(-8, 8),
				rand_in(-8, 8), rand_in(-8, 8), rand_in(-8, 8),
				rand_in(-8, 8), rand_in(-8, 8), rand_in(-8, 8), rand_in(0, 8));
		end
		if (sel < 32) begin
			bx = rand_in(CMIN, CMAX);
			by = rand_in(CMIN, CMAX);
			bz = rand_in(CMIN, CMAX);
			return mk_query(rand_in(CMIN, CMAX), rand_in(CMIN, CMAX), rand_in(CMIN, CMAX),
				bx, by, bz, bx, by, bz, rand_in(0, RMAX));
		end
		if (sel < 38) begin
			return mk_query(extreme_coord(), extreme_coord(), extreme_coord(),
				extreme_coord(), extreme_coord(), extreme_coord(),
				extreme_coord(), extreme_coord(), extreme_coord(),
				($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 1 : RMAX));
		end
		return shaped_query();
	endfunction

	task automatic report_mismatch(string msg);
		if (errors < MAX_REPORTS) begin
			$display("MISMATCH at %0t ns: %s", $time, msg);
		end
		errors++;
	endtask

	task automatic send_query(cone_query_t q, pic_res_t want);
		int gap;
		gap = pick_gap();
		queued_verdicts.insert(queued_verdicts.size(), want);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'(q);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (awaited_verdicts.size() != 0 || queued_verdicts.size() != 0) begin
			@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		pic_res_t got, want, fresh;
		if (arst_n && s_tvalid && s_tready) begin
			fresh = queued_verdicts.pop_front();
			awaited_verdicts.insert(awaited_verdicts.size(), fresh);
			accepted_queries++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = pic_res_t'(m_tdata[1:0]);
			if (awaited_verdicts.size() == 0) begin
				report_mismatch("result item arrived with no query outstanding");
			end else begin
				want = awaited_verdicts.pop_front();
				if (got.inside_res !== want.inside_res) begin
					report_mismatch($sformatf("result %0d inside_res got %b want %b",
						checked_results, got.inside_res, want.inside_res));
				end
				if (got.degenerate !== want.degenerate) begin
					report_mismatch($sformatf("result %0d degenerate got %b want %b",
						checked_results, got.degenerate, want.degenerate));
				end
				inside_seen += want.inside_res;
				degen_seen += want.degenerate;
				checked_results++;
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles, %0d results outstanding.",
				STALL_LIMIT, awaited_verdicts.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = burst ? 1 : $urandom_range(1, 30);
			m_tready <= 1'b1;
			repeat (hold) @(posedge clk);
			hold = pick_gap();
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	initial begin
		pic_res_t want;
		cone_query_t q;
		int i;
		dir_rows = '{
			'{mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, V_DEGEN},
			'{mk_query(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, RMAX), 1'b1, V_DEGEN},
			'{mk_query(5, -7, 9, 5, -7, 9, 5, -7, 9, 100), 1'b1, V_DEGEN},
			'{mk_query(0, 0, 50, 0, 0, 0, 0, 0, 100, 50), 1'b1, V_INSIDE},
			'{mk_query(0, 0, 100, 0, 0, 0, 0, 0, 100, 0), 1'b1, V_INSIDE},
			'{mk_query(0, 0, 101, 0, 0, 0, 0, 0, 100, RMAX), 1'b1, V_OUTSIDE},
			'{mk_query(0, 0, -10, 0, 0, 0, 0, 0, 100, 0), 1'b0, V_OUTSIDE},
			'{mk_query(60, 0, -10, 0, 0, 0, 0, 0, 100, 50), 1'b1, V_OUTSIDE},
			'{mk_query(54, 0, -10, 0, 0, 0, 0, 0, 100, 50), 1'b0, V_OUTSIDE},
			'{mk_query(1, 0, 50, 0, 0, 0, 0, 0, 100, 0), 1'b1, V_OUTSIDE},
			'{mk_query(0, 0, 50, 0, 0, 0, 0, 0, 100, 0), 1'b1, V_INSIDE},
			'{mk_query(3, 0, 0, 0, 0, 0, 0, 0, 4, 3), 1'b1, V_INSIDE},
			'{mk_query(3, 0, 1, 0, 0, 0, 0, 0, 4, 3), 1'b0, V_OUTSIDE},
			'{mk_query(2, 0, 1, 0, 0, 0, 0, 0, 4, 3), 1'b0, V_OUTSIDE},
			'{mk_query(1, 0, -5, 0, 0, 0, 0, 0, 10, 0), 1'b1, V_OUTSIDE},
			'{mk_query(0, 0, 11, 0, 0, 0, 0, 0, 10, RMAX), 1'b1, V_OUTSIDE},
			'{mk_query(0, 0, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, RMAX), 1'b0, V_OUTSIDE},
			'{mk_query(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0), 1'b1, V_INSIDE},
			'{mk_query(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN + 1, RMAX),
				1'b0, V_OUTSIDE},
			'{mk_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX - 1, RMAX),
				1'b1, V_OUTSIDE},
			'{mk_query(0, 999, 0, 1000, 0, 0, -1000, 0, 0, 1000), 1'b0, V_OUTSIDE},
			'{mk_query(CMIN, 0, CMAX, 0, CMIN, 0, 0, CMIN, 1, RMAX), 1'b0, V_OUTSIDE}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIR; i++) begin
			want = dir_rows[i].typed ? dir_rows[i].want : cone_verdict(dir_rows[i].q);
			send_query(dir_rows[i].q, want);
		end
		wait_results_drained();

		for (i = 0; i < RANDOM_QUERIES; i++) begin
			if (i % 250 == 0) begin
				burst = ($urandom_range(0, 3) == 0);
			end
			if (i == RANDOM_QUERIES / 2) begin
				wait_results_drained();
			end
			q = random_query();
			send_query(q, cone_verdict(q));
		end
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results for %0d queries: %0d inside, %0d with a degenerate axis.",
			checked_results, accepted_queries, inside_seen, degen_seen);
		$display("%s %s", "Queries covered rims, apex, behind-base widening,",
			"beyond-apex and extreme coordinates.");
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: point_in_cone_test_unit.f
rtl/pic_pkg.sv
rtl/pic_mul.sv
rtl/pic_dly.sv
rtl/point_in_cone_test_unit.sv
test/point_in_cone_test_unit_tb.sv
